// File: rtl/utf8n_pkg.sv
package utf8n_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH         = 4;
    localparam int CFG_INDEX_BITS      = 2;
    localparam int NUM_SLOTS           = 6;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOWERCASE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACCENT_STRIP = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CJK_SPLIT    = 2'd2;

    // result slots of one command, in emission order
    localparam logic [2:0] SLOT_PRE   = 3'd0;
    localparam logic [2:0] SLOT_BYTE0 = 3'd1;
    localparam logic [2:0] SLOT_POST  = 3'd5;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_SPAN = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  norm_byte;
        logic [31:0] span_start;
        logic [31:0] span_end;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic lowercase_enable;
        logic accent_strip_enable;
        logic cjk_split_enable;
    } t_cfg;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [31:0]          pre_start;
        logic [31:0]          pre_end;
        logic [3:0][7:0]      bytes;
        logic [31:0]          post_start;
        logic [31:0]          post_end;
    } t_cmd;

endpackage

// File: rtl/utf8n_front.sv
module utf8n_front #(
    parameter int OFFSET_BITS = utf8n_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  utf8n_pkg::t_cfg   i_cfg,
    input  logic              i_valid,
    input  utf8n_pkg::t_item  i_item,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output utf8n_pkg::t_cmd   o_cmd
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [8*64-1:0] LATIN1_BASE =
        "AAAAAAACEEEEIIIIDNOOOOOxOUUUUYPsaaaaaaaceeeeiiiidnooooo/ouuuuypy";

    logic [20:0]            r_accum, n_accum;
    logic [1:0]             r_pend, n_pend;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic                   r_word_open, n_word_open;
    logic [OFFSET_BITS-1:0] r_word_begin, n_word_begin;

    logic                   accept;
    logic [7:0]             b;
    logic                   have;
    logic [20:0]            c;
    logic [20:0]            cn;
    logic [20:0]            ce;
    logic                   drop, space, split, normal, emit;
    logic [2:0]             nbytes;
    logic [3:0]             bmask;
    logic [3:0][7:0]        enc;
    logic [OFFSET_BITS-1:0] off_after;
    utf8n_pkg::t_cmd        cmd;

    function automatic logic [20:0] f_strip(input logic [20:0] x);
        logic [7:0] base;
        base = LATIN1_BASE[{~x[5:0], 3'b000} +: 8];
        if (x >= 21'h0000C0 && x <= 21'h0000FF && base != "x" && base != "/") begin
            return {13'd0, base};
        end
        return x;
    endfunction

    function automatic logic [20:0] f_lower(input logic [20:0] x);
        if (x >= 21'h41 && x <= 21'h5A) begin
            return x + 21'd32;
        end
        if (x >= 21'hC0 && x <= 21'hDE && x != 21'hD7) begin
            return x + 21'h20;
        end
        return x;
    endfunction

    function automatic logic f_space(input logic [20:0] x);
        return x == 21'h20 || x == 21'h09 || x == 21'h0A || x == 21'h0D ||
               x == 21'h0C || x == 21'hA0;
    endfunction

    function automatic logic f_cjk(input logic [20:0] x);
        return (x >= 21'h4E00 && x <= 21'h9FFF) || (x >= 21'h3400 && x <= 21'h4DBF) ||
               (x >= 21'hF900 && x <= 21'hFAFF) ||
               (x >= 21'h20000 && x <= 21'h2A6DF);
    endfunction

    function automatic logic f_punct(input logic [20:0] x);
        return (x >= 21'd33 && x <= 21'd47) || (x >= 21'd58 && x <= 21'd64) ||
               (x >= 21'd91 && x <= 21'd96) || (x >= 21'd123 && x <= 21'd126);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] f_sat_add(
        input logic [OFFSET_BITS-1:0] x,
        input logic [2:0]             k
    );
        logic [OFFSET_BITS:0] s;
        s = {1'b0, x} + (OFFSET_BITS+1)'(k);
        return s[OFFSET_BITS] ? OFF_MAX : s[OFFSET_BITS-1:0];
    endfunction

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign b       = i_item.text_byte;

    always_comb begin
        n_accum      = r_accum;
        n_pend       = r_pend;
        n_off        = r_off;
        n_word_open  = r_word_open;
        n_word_begin = r_word_begin;
        have         = 1'b0;
        c            = '0;

        // utf-8 decode
        if (r_pend == 2'd0) begin
            if (!b[7]) begin
                have = 1'b1;
                c    = {13'd0, b};
            end else if (b[7:5] == 3'b110) begin
                n_accum = {16'd0, b[4:0]};
                n_pend  = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_accum = {17'd0, b[3:0]};
                n_pend  = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                n_accum = {18'd0, b[2:0]};
                n_pend  = 2'd3;
            end
        end else begin
            n_accum = {r_accum[14:0], b[5:0]};
            n_pend  = r_pend - 2'd1;
            if (r_pend == 2'd1) begin
                have = 1'b1;
                c    = {r_accum[14:0], b[5:0]};
            end
        end

        // classify
        space = f_space(c);
        drop  = c == 21'd0 || c == 21'hFFFD || (c < 21'h20 && !space) ||
                c == 21'h7F || (c >= 21'h80 && c <= 21'h9F);
        split  = have && !drop && !space &&
                 ((i_cfg.cjk_split_enable && f_cjk(c)) || f_punct(c));
        normal = have && !drop && !space && !split;
        emit   = split || normal;

        // normalize
        cn = c;
        if (i_cfg.accent_strip_enable) cn = f_strip(cn);
        if (i_cfg.lowercase_enable) cn = f_lower(cn);
        if (i_cfg.accent_strip_enable) cn = f_strip(cn);
        ce = split ? c : cn;

        // re-encode
        enc = '0;
        if (ce < 21'h80) begin
            nbytes = 3'd1;
            enc[0] = ce[7:0];
        end else if (ce < 21'h800) begin
            nbytes = 3'd2;
            enc[0] = {3'b110, ce[10:6]};
            enc[1] = {2'b10, ce[5:0]};
        end else if (ce < 21'h10000) begin
            nbytes = 3'd3;
            enc[0] = {4'b1110, ce[15:12]};
            enc[1] = {2'b10, ce[11:6]};
            enc[2] = {2'b10, ce[5:0]};
        end else begin
            nbytes = 3'd4;
            enc[0] = {5'b11110, ce[20:18]};
            enc[1] = {2'b10, ce[17:12]};
            enc[2] = {2'b10, ce[11:6]};
            enc[3] = {2'b10, ce[5:0]};
        end
        case (nbytes)
            3'd1:    bmask = 4'b0001;
            3'd2:    bmask = 4'b0011;
            3'd3:    bmask = 4'b0111;
            default: bmask = 4'b1111;
        endcase
        off_after = f_sat_add(r_off, nbytes);

        cmd            = '0;
        cmd.bytes      = enc;
        cmd.pre_start  = 32'(r_word_begin);
        cmd.pre_end    = 32'(r_off);
        cmd.post_start = 32'(r_off);
        cmd.post_end   = 32'(off_after);

        if (have && (space || split) && r_word_open) begin
            cmd.mask[utf8n_pkg::SLOT_PRE] = 1'b1;
            n_word_open = 1'b0;
        end
        if (emit) begin
            cmd.mask[utf8n_pkg::SLOT_BYTE0 +: 4] = bmask;
            n_off = off_after;
        end
        if (normal && !r_word_open) begin
            n_word_open  = 1'b1;
            n_word_begin = r_off;
        end
        if (split) begin
            cmd.mask[utf8n_pkg::SLOT_POST] = 1'b1;
        end else if (i_item.end_of_text && n_word_open) begin
            cmd.mask[utf8n_pkg::SLOT_POST] = 1'b1;
            cmd.post_start = 32'(n_word_begin);
            cmd.post_end   = 32'(n_off);
        end

        if (i_item.end_of_text) begin
            n_accum      = '0;
            n_pend       = '0;
            n_off        = '0;
            n_word_open  = 1'b0;
            n_word_begin = '0;
        end
    end

    assign o_push = accept && (cmd.mask != '0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum      <= '0;
            r_pend       <= '0;
            r_off        <= '0;
            r_word_open  <= 1'b0;
            r_word_begin <= '0;
        end else if (accept) begin
            r_accum      <= n_accum;
            r_pend       <= n_pend;
            r_off        <= n_off;
            r_word_open  <= n_word_open;
            r_word_begin <= n_word_begin;
        end
    end

endmodule

// File: rtl/utf8n_queue.sv
module utf8n_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utf8n_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output utf8n_pkg::t_cmd o_head
);

    localparam int DEPTH    = utf8n_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    utf8n_pkg::t_cmd       r_mem [DEPTH];
    logic [PTR_BITS-1:0]   r_wptr, r_rptr;
    logic [CNT_BITS-1:0]   r_count;
    logic                  do_push, do_pop;

    assign o_full  = r_count == CNT_BITS'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= (r_wptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (do_pop)  r_rptr <= (r_rptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/utf8n_back.sv
module utf8n_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  utf8n_pkg::t_cmd    i_head,
    output logic               o_pop,
    output logic               o_valid,
    output utf8n_pkg::t_result o_result,
    input  logic               i_stall
);

    localparam int NS = utf8n_pkg::NUM_SLOTS;

    logic [NS-1:0]      r_done;
    logic               r_valid;
    utf8n_pkg::t_result r_out;

    logic [NS-1:0]      rem, rest;
    logic [2:0]         sel;
    logic [1:0]         byte_idx;
    logic               last, load;
    utf8n_pkg::t_result res;

    always_comb begin
        rem = i_head.mask & ~r_done;
        sel = utf8n_pkg::SLOT_POST;
        for (int i = NS - 1; i >= 0; i--) begin
            if (rem[i]) sel = 3'(i);
        end
        rest     = rem & ~(NS'(1) << sel);
        last     = rest == '0;
        byte_idx = 2'(sel - utf8n_pkg::SLOT_BYTE0);

        res             = '0;
        res.last_of_run = last;
        case (sel)
            utf8n_pkg::SLOT_PRE: begin
                res.kind       = utf8n_pkg::KIND_SPAN;
                res.span_start = i_head.pre_start;
                res.span_end   = i_head.pre_end;
            end
            utf8n_pkg::SLOT_POST: begin
                res.kind       = utf8n_pkg::KIND_SPAN;
                res.span_start = i_head.post_start;
                res.span_end   = i_head.post_end;
            end
            default: begin
                res.kind      = utf8n_pkg::KIND_BYTE;
                res.norm_byte = i_head.bytes[byte_idx];
            end
        endcase
    end

    assign load     = i_q_valid && (!r_valid || !i_stall);
    assign o_pop    = load && last;
    assign o_valid  = r_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_done  <= last ? '0 : (r_done | (NS'(1) << sel));
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/utf8_text_normalizer_word_splitter.sv
// utf-8 text normalizer and word splitter
//
// input channel: one text byte per item (i_valid / o_stall), end_of_text on
// the final byte of a text. output channel: normalized bytes (kind 0) and
// word spans (kind 1) as output byte offsets (o_valid / i_stall);
// last_of_run marks the final result caused by an input byte.
// config channel: i_cfg_valid with i_cfg_index / i_cfg_data, o_cfg_ready is
// always high; write only while the block is idle.
//
// an item is decoded, classified and turned into a command in the cycle it
// is accepted; the command enters a 4-entry queue. the first result is
// registered in the output stage from the head of the queue. one item per
// cycle is taken while the queue has room; the output stage drains one result
// per cycle while i_stall is low, and an item yields 0 to 6 results.
// o_stall rises when the queue is full, which bursts of multi-result items
// or a stalled receiver cause. a stalled result holds on o_result.
// reset clears decode state, offsets, queue, output valid and config registers;
// end_of_text closes the open word and returns the decode state to reset.
module utf8_text_normalizer_word_splitter #(
    parameter int OFFSET_BITS = utf8n_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  utf8n_pkg::t_item                     i_item,
    output logic                                 o_stall,
    output logic                                 o_valid,
    output utf8n_pkg::t_result                   o_result,
    input  logic                                 i_stall,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [utf8n_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic                                 i_cfg_data
);

    utf8n_pkg::t_cfg r_cfg;
    utf8n_pkg::t_cmd push_cmd, head;
    logic            push, pop, q_full, q_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                utf8n_pkg::CFG_LOWERCASE:    r_cfg.lowercase_enable    <= i_cfg_data;
                utf8n_pkg::CFG_ACCENT_STRIP: r_cfg.accent_strip_enable <= i_cfg_data;
                utf8n_pkg::CFG_CJK_SPLIT:    r_cfg.cjk_split_enable    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    utf8n_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    utf8n_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    utf8n_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .i_stall   (i_stall)
    );

    // the results of one byte come out without gaps
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_result.last_of_run |=> o_valid)
        else $error("gap inside a run of results");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind == utf8n_pkg::KIND_BYTE |->
            o_result.span_start == '0 && o_result.span_end == '0)
        else $error("byte item carries span fields");

    a_span_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind == utf8n_pkg::KIND_SPAN |-> o_result.norm_byte == '0)
        else $error("span item carries a byte");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into a full queue");

endmodule
